// ===== rtl/swiglu_gate_forward_backward_core_macros.svh =====
// Assertion helpers for the SwiGLU gate core checker.
// Both expect signals named clk and arst_n in the scope of use.
`ifndef SWIGLU_GATE_FORWARD_BACKWARD_CORE_MACROS_SVH
`define SWIGLU_GATE_FORWARD_BACKWARD_CORE_MACROS_SVH

// Assert a property on every rising clock edge outside reset.
`define SWG_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Assert that cons holds in the cycle after ante, outside reset.
`define SWG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/swg_pkg.sv =====
package swg_pkg;

	localparam int SIG_BITS     = 16;
	localparam int SIG_DEPTH    = 256;
	localparam int SIG_IDX_BITS = 8;

	// exp(-1/16) in Q32, one step of the exponential recurrence
	localparam logic [63:0] EXP_STEP = 64'd4034748382;

	typedef logic [SIG_DEPTH-1:0][SIG_BITS-1:0] sig_rom_t;

	// Sigmoid table over [-8,8) in steps of 1/16, unsigned Q0.16.
	// Evaluated at elaboration; the quotient is a restoring division.
	function automatic sig_rom_t build_sig_rom();
		sig_rom_t    rom;
		logic [63:0] v;
		logic [63:0] den;
		logic [63:0] rem;
		logic [63:0] dsh;
		logic [16:0] q;
		logic [16:0] cq;
		rom = '0;
		v   = 64'h1_0000_0000;
		for (int k = 0; k <= 128; k++) begin
			den = 64'h1_0000_0000 + v;
			rem = (64'd1 << 48) + (den >> 1);
			q   = '0;
			for (int i = 16; i >= 0; i--) begin
				dsh = den << i;
				if (rem >= dsh) begin
					rem  = rem - dsh;
					q[i] = 1'b1;
				end
			end
			cq = 17'h1_0000 - q;
			if (k < 128)
				rom[128 + k] = q[SIG_BITS-1:0];
			if (k > 0)
				rom[128 - k] = cq[SIG_BITS-1:0];
			v = (v * EXP_STEP + 64'h8000_0000) >> 32;
		end
		return rom;
	endfunction

	localparam sig_rom_t SIG_ROM = build_sig_rom();

endpackage

// ===== rtl/swg_sigmoid_lut.sv =====
module swg_sigmoid_lut #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS  = 12
) (
	input  logic signed [DATA_WIDTH-1:0]   gate,
	output logic [swg_pkg::SIG_BITS-1:0]   sig
);
	import swg_pkg::*;

	localparam int EW = ((DATA_WIDTH > FRAC_BITS + 4) ? DATA_WIDTH : FRAC_BITS + 4) + 1;
	localparam logic signed [EW-1:0] SPAN = EW'(8) << FRAC_BITS;

	logic signed [EW-1:0]     ax;
	logic signed [EW-1:0]     off;
	logic [SIG_IDX_BITS-1:0]  idx;

	always_comb begin
		ax  = EW'(gate);
		off = ax + SPAN;
		// saturate below -8 and at or above +8
		if (ax < -SPAN) begin
			idx = '0;
		end else if (ax >= SPAN) begin
			idx = '1;
		end else begin
			idx = off[FRAC_BITS-4 +: SIG_IDX_BITS];
		end
		sig = SIG_ROM[idx];
	end

endmodule

// ===== rtl/swiglu_gate_forward_backward_core.sv =====
// SwiGLU gate core: one item per clock, five pipeline stages from input
// handshake to output register (sigmoid table, swish, derivative and the
// single products, partial products of the three-way gate gradient, then
// rounding and saturation). Throughput is one item per cycle whenever the
// output side takes results; stalls back up stage by stage and bubbles are
// squeezed out, so an empty stage still takes an item. tuser carries the
// action (0 forward, 1 backward). Forward returns swish(a)*b in primary_out
// and zero in value_grad; backward returns g*b*swish'(a) and g*swish(a).
// With gradient_disabled set, backward items are taken and dropped with no
// result. Write gradient_disabled only while the block holds no item.
module swiglu_gate_forward_backward_core #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS  = 12,
	localparam int IN_TDATA_W  = ((3 * DATA_WIDTH + 7) / 8) * 8,
	localparam int OUT_TDATA_W = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic                   cfg_wr_data,     // gradient_disabled
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,    // gate_in, value_in, upstream_grad
	input  logic                   s_axis_tuser,    // action
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata     // primary_out, value_grad
);
	import swg_pkg::*;

	localparam int W     = DATA_WIDTH;
	localparam int SW_W  = W + 1;
	localparam int PA_W  = W + SIG_BITS + 1;
	localparam int OM_W  = ((SW_W > FRAC_BITS + 1) ? SW_W : FRAC_BITS + 1) + 1;
	localparam int T_W   = OM_W + SIG_BITS + 1;
	localparam int D_W   = OM_W + 1;
	localparam int M_W   = 2 * W + 2;
	localparam int P_W   = W + D_W;
	localparam int TOT_W = 2 * W + D_W + 1;

	localparam logic [PA_W:0]          RND16 = (PA_W + 1)'(1) << 15;
	localparam logic [T_W:0]           RNDT  = (T_W + 1)'(1) << 15;
	localparam logic signed [OM_W-1:0] ONE   = OM_W'(1) << FRAC_BITS;
	localparam logic [M_W-1:0]         RNDF  = M_W'(1) << (FRAC_BITS - 1);
	localparam logic [TOT_W-1:0]       RND2F = TOT_W'(1) << (2 * FRAC_BITS - 1);

	function automatic logic [W-1:0] sat_w(input logic big, input logic neg,
		input logic [W-1:0] q);
		logic [W-1:0] r;
		if (big) begin
			r = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		end else begin
			r = neg ? -q : q;
		end
		return r;
	endfunction

	logic grad_dis_q;
	logic en1, en2, en3, en4, en5;
	logic in_acc;

	// stage 1
	logic                   vld_s1, act_s1;
	logic signed [W-1:0]    a_s1, b_s1, g_s1;
	logic [SIG_BITS-1:0]    sig_s1;
	logic [SIG_BITS-1:0]    sig_lut;
	// stage 2
	logic                   vld_s2, act_s2;
	logic signed [W-1:0]    b_s2, g_s2;
	logic [SIG_BITS-1:0]    sig_s2;
	logic signed [SW_W-1:0] sw_s2;
	// stage 3
	logic                   vld_s3, act_s3;
	logic [2*W:0]           mx_s3;
	logic                   mneg_s3;
	logic [2*W-1:0]         gb_s3;
	logic                   gbneg_s3;
	logic signed [D_W-1:0]  d_s3;
	// stage 4
	logic                   vld_s4, act_s4;
	logic [W-1:0]           mres_s4;
	logic                   gneg_s4;
	logic [P_W-1:0]         pl_s4, ph_s4;
	// stage 5
	logic                   vld_s5;
	logic [W-1:0]           prim_s5, vgrad_s5;

	// stage 2 logic
	logic signed [PA_W-1:0] pa;
	logic [PA_W-1:0]        pa_mag;
	logic [PA_W:0]          pa_sum;
	logic [SW_W-1:0]        sw_r;
	logic signed [SW_W-1:0] sw_c;

	// stage 3 logic
	logic signed [OM_W-1:0] om;
	logic signed [T_W-1:0]  tp;
	logic [T_W-1:0]         tp_mag;
	logic [T_W:0]           tp_sum;
	logic signed [D_W-1:0]  tp_r;
	logic signed [D_W-1:0]  d_c;
	logic signed [W-1:0]    sel;
	logic [SW_W-1:0]        sw_mag;
	logic [W-1:0]           sel_mag, g_mag, b_mag;

	// stage 4 logic
	logic [M_W-1:0]         m_sum;
	logic [M_W-1:0]         m_q;
	logic [D_W-1:0]         d_mag;

	// stage 5 logic
	logic [TOT_W-1:0]       g_tot;
	logic [TOT_W-1:0]       g_q;
	logic [W-1:0]           gate_res;

	assign en5 = !vld_s5 || m_axis_tready;
	assign en4 = !vld_s4 || en5;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;

	assign s_axis_tready = en1;
	assign in_acc        = s_axis_tvalid && en1;

	swg_sigmoid_lut #(
		.DATA_WIDTH(DATA_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_sig (
		.gate(s_axis_tdata[W-1:0]),
		.sig (sig_lut)
	);

	always_comb begin
		pa     = a_s1 * $signed({1'b0, sig_s1});
		pa_mag = pa[PA_W-1] ? -pa : pa;
		pa_sum = {1'b0, pa_mag} + RND16;
		sw_r   = pa_sum[16 +: SW_W];
		sw_c   = pa[PA_W-1] ? -$signed(sw_r) : $signed(sw_r);
	end

	always_comb begin
		// swish' = swish + sigmoid * (1 - swish)
		om      = ONE - OM_W'(sw_s2);
		tp      = $signed({1'b0, sig_s2}) * om;
		tp_mag  = tp[T_W-1] ? -tp : tp;
		tp_sum  = {1'b0, tp_mag} + RNDT;
		tp_r    = $signed(tp_sum[16 +: D_W]);
		d_c     = D_W'(sw_s2) + (tp[T_W-1] ? -tp_r : tp_r);
		sel     = act_s2 ? g_s2 : b_s2;
		sw_mag  = sw_s2[SW_W-1] ? -sw_s2 : sw_s2;
		sel_mag = sel[W-1] ? -sel : sel;
		g_mag   = g_s2[W-1] ? -g_s2 : g_s2;
		b_mag   = b_s2[W-1] ? -b_s2 : b_s2;
	end

	always_comb begin
		m_sum = M_W'(mx_s3) + RNDF;
		m_q   = m_sum >> FRAC_BITS;
		d_mag = d_s3[D_W-1] ? -d_s3 : d_s3;
	end

	always_comb begin
		g_tot    = (TOT_W'(ph_s4) << W) + TOT_W'(pl_s4) + RND2F;
		g_q      = g_tot >> (2 * FRAC_BITS);
		gate_res = sat_w(|g_q[TOT_W-1:W-1], gneg_s4, g_q[W-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grad_dis_q <= 1'b0;
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			vld_s3     <= 1'b0;
			vld_s4     <= 1'b0;
			vld_s5     <= 1'b0;
		end else begin
			if (cfg_wr_en)
				grad_dis_q <= cfg_wr_data;
			// drop backward items while gradients are disabled
			if (en1)
				vld_s1 <= in_acc && !(s_axis_tuser && grad_dis_q);
			if (en2)
				vld_s2 <= vld_s1;
			if (en3)
				vld_s3 <= vld_s2;
			if (en4)
				vld_s4 <= vld_s3;
			if (en5)
				vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			act_s1 <= s_axis_tuser;
			a_s1   <= s_axis_tdata[W-1:0];
			b_s1   <= s_axis_tdata[2*W-1:W];
			g_s1   <= s_axis_tdata[3*W-1:2*W];
			sig_s1 <= sig_lut;
		end
		if (en2) begin
			act_s2 <= act_s1;
			b_s2   <= b_s1;
			g_s2   <= g_s1;
			sig_s2 <= sig_s1;
			sw_s2  <= sw_c;
		end
		if (en3) begin
			act_s3   <= act_s2;
			mx_s3    <= (2 * W + 1)'(sw_mag) * (2 * W + 1)'(sel_mag);
			mneg_s3  <= sw_s2[SW_W-1] ^ sel[W-1];
			gb_s3    <= (2 * W)'(g_mag) * (2 * W)'(b_mag);
			gbneg_s3 <= g_s2[W-1] ^ b_s2[W-1];
			d_s3     <= d_c;
		end
		if (en4) begin
			act_s4  <= act_s3;
			mres_s4 <= sat_w(|m_q[M_W-1:W-1], mneg_s3, m_q[W-1:0]);
			gneg_s4 <= gbneg_s3 ^ d_s3[D_W-1];
			pl_s4   <= P_W'(gb_s3[W-1:0]) * P_W'(d_mag);
			ph_s4   <= P_W'(gb_s3[2*W-1:W]) * P_W'(d_mag);
		end
		if (en5) begin
			prim_s5  <= act_s4 ? gate_res : mres_s4;
			vgrad_s5 <= act_s4 ? mres_s4 : '0;
		end
	end

	assign m_axis_tvalid = vld_s5;
	assign m_axis_tdata  = OUT_TDATA_W'({vgrad_s5, prim_s5});

endmodule

// ===== rtl/swg_checker.sv =====
`include "swiglu_gate_forward_backward_core_macros.svh"

module swg_checker #(
	parameter int DATA_WIDTH = 16,
	localparam int OUT_TDATA_W = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   s_axis_tuser,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	logic fw_acc;
	logic flow;

	assign fw_acc = s_axis_tvalid && s_axis_tready && !s_axis_tuser && arst_n;
	assign flow   = m_axis_tready && arst_n;

	// a waiting result holds
	`SWG_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata), "output item changed while stalled")

	// an empty output register means the pipeline can take an item
	`SWG_ASSERT(a_room, !m_axis_tvalid |-> s_axis_tready, "input stalled with output empty")

	// a forward item always yields a result when the output side does not stall
	`SWG_ASSERT(a_fwd_latency, $past(fw_acc, 5) && $past(flow, 1) && $past(flow, 2) && $past(flow, 3) && $past(flow, 4) |-> m_axis_tvalid, "forward item result missing")

endmodule

bind swiglu_gate_forward_backward_core swg_checker #(
	.DATA_WIDTH(DATA_WIDTH)
) u_swg_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 1ps

// Tracks SwiGLU results the core owes: forward swish(a)*b, backward gate and value gradients.
class swiglu_result_book;
	typedef struct packed {
		logic [15:0] primary;
		logic [15:0] vgrad;
	} swiglu_pair_t;

	localparam logic [127:0] EXP_Q32 = 128'd4034748382;

	logic [15:0]  sigmoid_rom [256];
	logic         grad_off;
	swiglu_pair_t awaited [$];
	int unsigned  errors;
	int unsigned  checked;

	// Sigmoid over [-8,8) in steps of 1/16, Q0.16; mirror the upper half for x < 0.
	function new();
		logic [127:0] v;
		logic [127:0] den;
		logic [127:0] s;
		logic [127:0] comp;
		v = 128'd1 << 32;
		for (int k = 0; k <= 128; k++) begin
			den  = (128'd1 << 32) + v;
			s    = ((128'd1 << 48) + (den >> 1)) / den;
			comp = 128'd65536 - s;
			if (k < 128)
				sigmoid_rom[128 + k] = s[15:0];
			if (k > 0)
				sigmoid_rom[128 - k] = comp[15:0];
			v = (v * EXP_Q32 + (128'd1 << 31)) >> 32;
		end
		grad_off = 1'b0;
		errors   = 0;
		checked  = 0;
	endfunction

	// Round to nearest, ties away from zero.
	function longint round_away(longint x, int n);
		longint m;
		m = ((x < 0 ? -x : x) + (longint'(1) << (n - 1))) >>> n;
		return x < 0 ? -m : m;
	endfunction

	function logic [15:0] clamp16(longint x);
		if (x > 32767)
			return 16'h7FFF;
		if (x < -32768)
			return 16'h8000;
		return x[15:0];
	endfunction

	// Returns 1 when the item leaves a result behind.
	function bit note_item(logic act, logic [15:0] a_w, logic [15:0] b_w, logic [15:0] g_w);
		longint       a;
		longint       b;
		longint       g;
		longint       sig;
		longint       sw;
		longint       d;
		swiglu_pair_t r;
		a   = $signed(a_w);
		b   = $signed(b_w);
		g   = $signed(g_w);
		sig = sigmoid_rom[int'((a + 32768) >>> 8)];
		sw  = round_away(a * sig, 16);
		if (act == 1'b0) begin
			r.primary = clamp16(round_away(sw * b, 12));
			r.vgrad   = 16'h0000;
		end else begin
			if (grad_off)
				return 1'b0;
			d         = sw + round_away(sig * (4096 - sw), 16);
			r.primary = clamp16(round_away(g * b * d, 24));
			r.vgrad   = clamp16(round_away(g * sw, 12));
		end
		awaited.push_back(r);
		return 1'b1;
	endfunction

	function void check_result(logic [15:0] primary, logic [15:0] vgrad);
		swiglu_pair_t r;
		if (awaited.size() == 0) begin
			$display("%0t: result %h/%h arrived with nothing outstanding", $time, primary, vgrad);
			errors++;
			return;
		end
		r = awaited.pop_front();
		checked++;
		if (primary !== r.primary) begin
			$display("%0t: primary_out expected %h got %h", $time, r.primary, primary);
			errors++;
		end
		if (vgrad !== r.vgrad) begin
			$display("%0t: value_grad expected %h got %h", $time, r.vgrad, vgrad);
			errors++;
		end
	endfunction
endclass

module tb;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 12;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_wr_en     = 1'b0;
	logic        cfg_wr_data   = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata  = '0;     // gate_in, value_in, upstream_grad
	logic        s_axis_tuser  = 1'b0;   // action
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;           // primary_out, value_grad

	swiglu_result_book book = new();

	int unsigned idle_pct     = 0;
	int unsigned stall_pct    = 0;
	int unsigned quiet_cycles = 0;
	int unsigned items_in     = 0;
	int unsigned fwd_items    = 0;
	int unsigned bwd_items    = 0;
	int unsigned dropped      = 0;

	swiglu_gate_forward_backward_core #(
		.DATA_WIDTH(16),
		.FRAC_BITS (12)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99, 0) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			items_in++;
			if (s_axis_tuser)
				bwd_items++;
			else
				fwd_items++;
			if (!book.note_item(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16],
					s_axis_tdata[47:32]))
				dropped++;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready)
			book.check_result(m_axis_tdata[15:0], m_axis_tdata[31:16]);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	// Half plain random words; the rest are the extremes and small magnitudes.
	function automatic logic [15:0] rand_word();
		logic [15:0] w;
		case ($urandom_range(7, 0))
			0: w = 16'h8000;
			1: w = 16'h7FFF;
			2: w = 16'($urandom_range(8191, 0)) - 16'd4096;
			3: w = 16'($urandom_range(2047, 0)) - 16'd1024;
			default: w = 16'($urandom);
		endcase
		return w;
	endfunction

	task automatic send_item(input logic act, input logic [15:0] a, input logic [15:0] b,
			input logic [15:0] g);
		while ($urandom_range(99, 0) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {g, b, a};
		s_axis_tuser  <= act;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic write_grad_config(input logic off);
		cfg_wr_en     <= 1'b1;
		cfg_wr_data   <= off;
		book.grad_off  = off;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Drop valid, wait out every owed result, then let dropped items clear the pipe.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (book.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_grad_config(1'b0);

		// forward: extremes, saturation both ways, zero gate, table index edges
		send_item(1'b0, 16'h8000, 16'h7FFF, 16'h0000);
		send_item(1'b0, 16'h7FFF, 16'h7FFF, 16'h0000);
		send_item(1'b0, 16'h7FFF, 16'h8000, 16'hFFFF);
		send_item(1'b0, 16'h0000, 16'h7FFF, 16'h7FFF);
		send_item(1'b0, 16'h0001, 16'h1000, 16'h0000);
		send_item(1'b0, 16'hFFFF, 16'h8000, 16'h0000);
		send_item(1'b0, 16'h1000, 16'h1000, 16'h0000);
		send_item(1'b0, 16'hF000, 16'h1000, 16'h0000);
		send_item(1'b0, 16'h00FF, 16'h7FFF, 16'h0000);
		send_item(1'b0, 16'h0100, 16'h8000, 16'h0000);
		send_item(1'b0, 16'h80FF, 16'h7FFF, 16'h0000);
		// backward: extremes of all three operands
		send_item(1'b1, 16'h8000, 16'h8000, 16'h8000);
		send_item(1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_item(1'b1, 16'h7FFF, 16'h8000, 16'h7FFF);
		send_item(1'b1, 16'h0000, 16'h1000, 16'h1000);
		send_item(1'b1, 16'h1000, 16'h1000, 16'h1000);
		send_item(1'b1, 16'hF000, 16'hF000, 16'h7FFF);
		send_item(1'b1, 16'hFFFF, 16'h0001, 16'h8000);
		send_item(1'b1, 16'h7F00, 16'h7FFF, 16'h8000);
		settle();

		// first layer: backward items are swallowed, forward still answers
		write_grad_config(1'b1);
		send_item(1'b1, 16'h1000, 16'h1000, 16'h1000);
		send_item(1'b0, 16'h1000, 16'h2000, 16'h0000);
		send_item(1'b1, 16'h8000, 16'h7FFF, 16'h7FFF);
		send_item(1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		settle();

		// idle patterns: none, sender, receiver, both; gradients off in two phases
		for (int ph = 0; ph < 8; ph++) begin
			idle_pct  = (ph % 4 == 1) ? 75 : (ph % 4 == 3) ? 11 : 0;
			stall_pct = (ph % 4 == 2) ? 75 : (ph % 4 == 3) ? 11 : 0;
			write_grad_config(ph == 2 || ph == 5);
			repeat (116)
				send_item(1'($urandom_range(1, 0)), rand_word(), rand_word(), rand_word());
			settle();
		end

		if (book.awaited.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, book.awaited.size());
			book.errors++;
		end
		$display("Ran %0d items (%0d forward, %0d backward, %0d dropped with gradients off)",
			items_in, fwd_items, bwd_items, dropped);
		$display("Checked %0d results under four idle/stall patterns and both gradient settings",
			book.checked);
		if (book.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
